FILE: design/mbar_pkg.sv
// Shared constants, types and helper functions for the Modbus ASCII read link.
package mbar_pkg;

   // Field widths
   localparam int unsigned NODE_W     = 8;
   localparam int unsigned REG_W      = 16;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned POS_W      = 5;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 48;

   // Query frame: ':' + 14 hex digits + CR + LF
   localparam int unsigned NIB_COUNT = 14;
   localparam int unsigned NIB_IDX_W = 4;
   localparam int unsigned TXC_W     = 5;
   localparam logic [TXC_W-1:0] TXC_FIRST_HEX = 5'd1;
   localparam logic [TXC_W-1:0] TXC_LAST_HEX  = 5'd14;
   localparam logic [TXC_W-1:0] TXC_LF        = 5'd16;

   // Response parser positions
   localparam logic [POS_W-1:0] POS_START      = 5'd0;
   localparam logic [POS_W-1:0] POS_DATA_FIRST = 5'd7;
   localparam logic [POS_W-1:0] POS_DATA_END   = 5'd15;
   localparam logic [POS_W-1:0] POS_MAX        = 5'd31;

   // Protocol bytes and characters
   localparam logic [NODE_W-1:0] NODE_RESET  = 8'h01;
   localparam logic [7:0]        FUNC_READ_IR = 8'h04;
   localparam logic [7:0]        COUNT_HI     = 8'h00;
   localparam logic [7:0]        COUNT_LO     = 8'h02;
   localparam logic [CHAR_W-1:0] CH_COLON     = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;

   // Operation selector on the request side
   typedef enum logic {
      OP_QUERY   = 1'b0,
      OP_RX_CHAR = 1'b1
   } op_type;

   // Result kind on the response side
   typedef enum logic {
      KIND_TX     = 1'b0,
      KIND_REPORT = 1'b1
   } kind_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Nibble to lowercase ASCII hex
   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h57 + {4'd0, nib};
      end
      return c;
   endfunction

   // ASCII hex (either case) to nibble, with a valid flag
   function automatic hex_digit_type hex_decode(input logic [CHAR_W-1:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h37);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

FILE: design/modbus_ascii_read_link.sv
// Modbus ASCII read-input-register link: query framer and response parser.
//
// Each request item is either a query (tuser 0) or one received character
// (tuser 1). A received character updates the parser registers and, on
// LF, loads a report into the response register. A query loads its ':' at
// once and then drives the remaining 16 frame characters from the frame
// register one per cycle while the response side takes them; the request
// side is held until the frame's LF has been loaded. The response register
// decouples the two sides: a new item is taken in the same cycle as the
// waiting result is taken.
module modbus_ascii_read_link (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,     // node_address
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [mbar_pkg::REQ_DATA_W-1:0] req_tdata, // register_base[15:0], channel_index, rx_char
   input  logic        req_tuser,          // operation
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [mbar_pkg::RSP_DATA_W-1:0] rsp_tdata, // tx_char[7:0], response_data, response_ok, zero pad
   output logic        rsp_tuser,          // kind
   output logic        rsp_tlast           // last
);

   // Request field split
   logic [mbar_pkg::REG_W-1:0]  req_base;
   logic [mbar_pkg::CHAN_W-1:0] req_chan;
   logic [mbar_pkg::CHAR_W-1:0] req_char;
   mbar_pkg::op_type            req_op;

   assign req_base = req_tdata[15:0];
   assign req_chan = req_tdata[23:16];
   assign req_char = req_tdata[31:24];
   assign req_op   = mbar_pkg::op_type'(req_tuser);

   // Registers
   logic [mbar_pkg::NODE_W-1:0]           node_ff;
   logic                                  tx_busy_ff, tx_busy_in;
   logic [mbar_pkg::TXC_W-1:0]            tx_count_ff, tx_count_in;
   logic [mbar_pkg::NIB_COUNT-1:0][3:0]   frame_ff, frame_in;
   logic [mbar_pkg::POS_W-1:0]            rx_pos_ff, rx_pos_in;
   logic [mbar_pkg::DATA_W-1:0]           rx_acc_ff, rx_acc_in;
   logic                                  rx_bad_ff, rx_bad_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   mbar_pkg::kind_type                    rsp_kind_ff, rsp_kind_in;
   logic [mbar_pkg::CHAR_W-1:0]           rsp_char_ff, rsp_char_in;
   logic                                  rsp_last_ff, rsp_last_in;
   logic [mbar_pkg::DATA_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                                  rsp_ok_ff, rsp_ok_in;

   // Handshake
   logic out_free;
   logic req_accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !tx_busy_ff && out_free;
   assign req_accept = req_tvalid && req_tready;

   // Query frame bytes and LRC
   logic [mbar_pkg::REG_W-1:0] q_addr;
   logic [7:0]                 q_sum;
   logic [7:0]                 q_lrc;

   assign q_addr = req_base + {8'd0, req_chan};
   assign q_sum  = node_ff + mbar_pkg::FUNC_READ_IR + q_addr[15:8] + q_addr[7:0]
                   + mbar_pkg::COUNT_HI + mbar_pkg::COUNT_LO;
   assign q_lrc  = 8'd0 - q_sum;

   // Current frame character while sending
   logic [mbar_pkg::NIB_IDX_W-1:0] nib_idx;
   logic [mbar_pkg::CHAR_W-1:0]    tx_sel_char;

   assign nib_idx = mbar_pkg::NIB_IDX_W'(tx_count_ff - mbar_pkg::TXC_FIRST_HEX);

   always_comb begin
      if ((tx_count_ff >= mbar_pkg::TXC_FIRST_HEX) && (tx_count_ff <= mbar_pkg::TXC_LAST_HEX)) begin
         tx_sel_char = mbar_pkg::hex_char(frame_ff[nib_idx]);
      end else if (tx_count_ff == mbar_pkg::TXC_LF) begin
         tx_sel_char = mbar_pkg::CH_LF;
      end else begin
         tx_sel_char = mbar_pkg::CH_CR;
      end
   end

   // Received character decode
   mbar_pkg::hex_digit_type rx_digit;
   logic                    rx_in_data;
   logic                    rx_ok;

   assign rx_digit   = mbar_pkg::hex_decode(req_char);
   assign rx_in_data = (rx_pos_ff >= mbar_pkg::POS_DATA_FIRST)
                       && (rx_pos_ff < mbar_pkg::POS_DATA_END);
   assign rx_ok      = !rx_bad_ff && (rx_pos_ff >= mbar_pkg::POS_DATA_END);

   // Next-state logic
   always_comb begin
      tx_busy_in   = tx_busy_ff;
      tx_count_in  = tx_count_ff;
      frame_in     = frame_ff;
      rx_pos_in    = rx_pos_ff;
      rx_acc_in    = rx_acc_ff;
      rx_bad_in    = rx_bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      if (tx_busy_ff && out_free) begin
         // next character of the frame in flight
         rsp_valid_in = 1'b1;
         rsp_kind_in  = mbar_pkg::KIND_TX;
         rsp_char_in  = tx_sel_char;
         rsp_last_in  = (tx_count_ff == mbar_pkg::TXC_LF);
         rsp_data_in  = '0;
         rsp_ok_in    = 1'b0;
         tx_count_in  = tx_count_ff + 5'd1;
         tx_busy_in   = (tx_count_ff != mbar_pkg::TXC_LF);
      end else if (req_accept) begin
         if (req_op == mbar_pkg::OP_QUERY) begin
            // start a frame: emit ':' now, keep the bytes for the rest
            rsp_valid_in = 1'b1;
            rsp_kind_in  = mbar_pkg::KIND_TX;
            rsp_char_in  = mbar_pkg::CH_COLON;
            rsp_last_in  = 1'b0;
            rsp_data_in  = '0;
            rsp_ok_in    = 1'b0;
            tx_busy_in   = 1'b1;
            tx_count_in  = mbar_pkg::TXC_FIRST_HEX;
            frame_in[0]  = node_ff[7:4];
            frame_in[1]  = node_ff[3:0];
            frame_in[2]  = mbar_pkg::FUNC_READ_IR[7:4];
            frame_in[3]  = mbar_pkg::FUNC_READ_IR[3:0];
            frame_in[4]  = q_addr[15:12];
            frame_in[5]  = q_addr[11:8];
            frame_in[6]  = q_addr[7:4];
            frame_in[7]  = q_addr[3:0];
            frame_in[8]  = mbar_pkg::COUNT_HI[7:4];
            frame_in[9]  = mbar_pkg::COUNT_HI[3:0];
            frame_in[10] = mbar_pkg::COUNT_LO[7:4];
            frame_in[11] = mbar_pkg::COUNT_LO[3:0];
            frame_in[12] = q_lrc[7:4];
            frame_in[13] = q_lrc[3:0];
         end else if (req_char == mbar_pkg::CH_LF) begin
            // end of line: report and restart the parser
            rsp_valid_in = 1'b1;
            rsp_kind_in  = mbar_pkg::KIND_REPORT;
            rsp_char_in  = '0;
            rsp_last_in  = 1'b0;
            rsp_data_in  = rx_ok ? rx_acc_ff : '0;
            rsp_ok_in    = rx_ok;
            rx_pos_in    = mbar_pkg::POS_START;
            rx_acc_in    = '0;
            rx_bad_in    = 1'b0;
         end else begin
            // position-indexed parse of one character
            if (rx_pos_ff == mbar_pkg::POS_START) begin
               if (req_char != mbar_pkg::CH_COLON) begin
                  rx_bad_in = 1'b1;
               end
            end else if (rx_in_data) begin
               if (rx_digit.valid) begin
                  rx_acc_in = {rx_acc_ff[mbar_pkg::DATA_W-5:0], rx_digit.value};
               end else begin
                  rx_bad_in = 1'b1;
               end
            end
            if (rx_pos_ff != mbar_pkg::POS_MAX) begin
               rx_pos_in = rx_pos_ff + 5'd1;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff      <= mbar_pkg::NODE_RESET;
         tx_busy_ff   <= 1'b0;
         tx_count_ff  <= '0;
         rx_pos_ff    <= mbar_pkg::POS_START;
         rx_acc_ff    <= '0;
         rx_bad_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            node_ff <= csr_write_data;
         end
         tx_busy_ff   <= tx_busy_in;
         tx_count_ff  <= tx_count_in;
         rx_pos_ff    <= rx_pos_in;
         rx_acc_ff    <= rx_acc_in;
         rx_bad_ff    <= rx_bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   // Outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_ok_ff, rsp_data_ff, rsp_char_ff};

   // Checks
   a_last_is_lf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |->
         (rsp_kind_ff == mbar_pkg::KIND_TX && rsp_char_ff == mbar_pkg::CH_LF))
      else $error("tlast on a result that is not the frame LF");

   a_busy_keeps_output: assert property (@(posedge clock) disable iff (reset)
      (tx_busy_ff && out_free) |=> rsp_valid_ff)
      else $error("frame in flight left the response register empty");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == mbar_pkg::OP_RX_CHAR && req_char != mbar_pkg::CH_LF
       && rx_pos_ff == mbar_pkg::POS_MAX) |=> (rx_pos_ff == mbar_pkg::POS_MAX))
      else $error("receive position wrapped");

   a_report_ok_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == mbar_pkg::KIND_REPORT && !rsp_ok_ff)
         |-> (rsp_data_ff == '0))
      else $error("bad report carries data");

   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == mbar_pkg::OP_QUERY) |=> (tx_busy_ff && !req_tready))
      else $error("request taken while a query frame is in flight");

endmodule

FILE: tb/modbus_ascii_read_link_test.sv
// Self-checking testbench for the Modbus ASCII read link: query frames and response reports.
module modbus_ascii_read_link_test;

   localparam int QUIET_LIMIT = 3000;   // cycles with no handshake before giving up
   localparam int TAIL_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'h0;     // register_base[15:0], channel_index, rx_char
   logic        req_tuser = mbar_pkg::OP_QUERY;  // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;             // tx_char[7:0], response_data, response_ok, zero pad
   logic        rsp_tuser;             // kind
   logic        rsp_tlast;             // last

   // one expected item on the response side
   typedef struct {
      mbar_pkg::kind_type kind;
      logic [7:0]  tx_char;
      logic        last;
      logic [31:0] data;
      logic        ok;
   } link_result_type;

   // Predicts query frames and parser reports, and checks what comes out
   class link_scoreboard_type;
      link_result_type awaited_results[$];
      logic [7:0]  node;
      logic [4:0]  rx_pos;
      logic [31:0] rx_word;
      logic        rx_bad;
      int          errors;
      string       lower_hex = "0123456789abcdef";

      function new();
         node    = mbar_pkg::NODE_RESET;
         rx_pos  = '0;
         rx_word = '0;
         rx_bad  = 1'b0;
         errors  = 0;
      endfunction

      function void push_result(mbar_pkg::kind_type k, logic [7:0] c, logic l,
                                logic [31:0] d, logic o);
         link_result_type r;
         r.kind    = k;
         r.tx_char = c;
         r.last    = l;
         r.data    = d;
         r.ok      = o;
         awaited_results.insert(awaited_results.size(), r);
      endfunction

      // either-case hex character to nibble; returns 0 if not a hex digit
      function logic decode_digit(logic [7:0] c, output logic [3:0] v);
         v = 4'h0;
         if (c >= "0" && c <= "9") v = 4'(c - "0");
         else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
         else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
         else return 1'b0;
         return 1'b1;
      endfunction

      // an item taken on the request side
      function void note_request(mbar_pkg::op_type op, logic [15:0] base, logic [7:0] chan,
                                 logic [7:0] ch);
         logic [15:0] addr;
         logic [7:0]  frame_bytes [7];
         logic [7:0]  sum;
         logic [3:0]  nib;
         logic        good;
         if (op == mbar_pkg::OP_QUERY) begin
            addr = base + 16'(chan);
            frame_bytes = '{node, mbar_pkg::FUNC_READ_IR, addr[15:8], addr[7:0],
                            mbar_pkg::COUNT_HI, mbar_pkg::COUNT_LO, 8'h00};
            sum = 8'h00;
            for (int i = 0; i < 6; i++) sum += frame_bytes[i];
            frame_bytes[6] = 8'h00 - sum;
            push_result(mbar_pkg::KIND_TX, mbar_pkg::CH_COLON, 1'b0, '0, 1'b0);
            for (int i = 0; i < 7; i++) begin
               push_result(mbar_pkg::KIND_TX, lower_hex[frame_bytes[i][7:4]], 1'b0, '0, 1'b0);
               push_result(mbar_pkg::KIND_TX, lower_hex[frame_bytes[i][3:0]], 1'b0, '0, 1'b0);
            end
            push_result(mbar_pkg::KIND_TX, mbar_pkg::CH_CR, 1'b0, '0, 1'b0);
            push_result(mbar_pkg::KIND_TX, mbar_pkg::CH_LF, 1'b1, '0, 1'b0);
         end else if (ch == mbar_pkg::CH_LF) begin
            good = !rx_bad && rx_pos >= mbar_pkg::POS_DATA_END;
            push_result(mbar_pkg::KIND_REPORT, 8'h00, 1'b0, good ? rx_word : 32'h0, good);
            rx_pos  = '0;
            rx_word = '0;
            rx_bad  = 1'b0;
         end else begin
            if (rx_pos == mbar_pkg::POS_START) begin
               if (ch != mbar_pkg::CH_COLON) rx_bad = 1'b1;
            end else if (rx_pos >= mbar_pkg::POS_DATA_FIRST &&
                         rx_pos < mbar_pkg::POS_DATA_END) begin
               if (decode_digit(ch, nib)) rx_word = {rx_word[27:0], nib};
               else rx_bad = 1'b1;
            end
            if (rx_pos != mbar_pkg::POS_MAX) rx_pos++;
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
         errors++;
      endtask

      // an item taken on the response side
      task check_response(mbar_pkg::kind_type kind, logic [7:0] c, logic l, logic [31:0] d,
                          logic o);
         link_result_type want;
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected item", {24'h0, c}, 32'h0);
            return;
         end
         want = awaited_results.pop_front();
         if (kind != want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
         if (c != want.tx_char) report_mismatch("tx_char", 32'(c), 32'(want.tx_char));
         if (l != want.last) report_mismatch("last", 32'(l), 32'(want.last));
         if (d != want.data) report_mismatch("response_data", d, want.data);
         if (o != want.ok) report_mismatch("response_ok", 32'(o), 32'(want.ok));
      endtask
   endclass

   link_scoreboard_type sb;
   int quiet_cycles = 0;
   int burst_left = 0;
   int items_sent = 0;
   int lf_sent = 0;
   int ready_mode = 0;
   int ready_run = 0;

   modbus_ascii_read_link uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watch both handshakes
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready)
            sb.note_request(mbar_pkg::op_type'(req_tuser), req_tdata[15:0], req_tdata[23:16],
                            req_tdata[31:24]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(mbar_pkg::kind_type'(rsp_tuser), rsp_tdata[7:0], rsp_tlast,
                              rsp_tdata[39:8], rsp_tdata[40]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: runs of always-ready, random stalls, alternate cycles, one in four
   always @(posedge clock) begin
      if (ready_run == 0) begin
         ready_mode <= $urandom_range(0, 3);
         ready_run  <= $urandom_range(16, 96);
      end else begin
         ready_run <= ready_run - 1;
      end
      case (ready_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_tready <= !rsp_tready;
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   // watchdog
   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one item on the request side, then the burst/gap pattern of the sender
   task automatic send_item(mbar_pkg::op_type op, logic [15:0] base, logic [7:0] chan,
                            logic [7:0] ch);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {ch, chan, base};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == mbar_pkg::OP_RX_CHAR && ch == mbar_pkg::CH_LF) lf_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom_range(20, 60);
      end
   endtask

   task automatic send_random_query();
      logic [15:0] base;
      logic [7:0]  chan;
      case ($urandom_range(0, 7))
         0: base = 16'h0000;
         1: base = 16'hFFFF;
         default: base = $urandom;
      endcase
      case ($urandom_range(0, 7))
         0: chan = 8'h00;
         1: chan = 8'hFF;
         default: chan = $urandom;
      endcase
      send_item(mbar_pkg::OP_QUERY, base, chan, $urandom);
   endtask

   // received character, now and then with a query slipped in ahead of it
   task automatic send_rx_char(logic [7:0] c);
      if ($urandom_range(0, 11) == 0) send_random_query();
      send_item(mbar_pkg::OP_RX_CHAR, $urandom, $urandom, c);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_rx_char(s[i]);
   endtask

   // sender stops until every awaited item has come, then lets the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_node(logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      sb.node = value;
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] random_hex_char(int value);
      string digits;
      logic [7:0] c;
      digits = "0123456789abcdef";
      c = digits[value];
      if (value >= 10 && $urandom_range(0, 1)) c = c - 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] random_non_lf();
      logic [7:0] c;
      do c = $urandom; while (c == mbar_pkg::CH_LF);
      return c;
   endfunction

   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      do c = $urandom;
      while (c == mbar_pkg::CH_LF || (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
             (c >= "A" && c <= "F"));
      return c;
   endfunction

   // one response line: mostly well formed, the rest broken in the usual ways
   task automatic send_random_frame();
      logic [7:0] line [$];
      logic [7:0] c;
      int shape;
      int digit_fill;
      int keep;
      shape = $urandom_range(0, 9);
      digit_fill = $urandom_range(0, 7);
      line.insert(line.size(), mbar_pkg::CH_COLON);
      for (int i = 0; i < 6; i++) begin
         c = ($urandom_range(0, 3) == 0) ? random_non_lf()
                                         : random_hex_char($urandom_range(0, 15));
         line.insert(line.size(), c);
      end
      for (int i = 0; i < 8; i++) begin
         if (digit_fill == 0) c = "0";
         else if (digit_fill == 1) c = random_hex_char(15);
         else c = random_hex_char($urandom_range(0, 15));
         line.insert(line.size(), c);
      end
      case (shape)
         5: begin   // long line, can run the position counter into saturation
            repeat ($urandom_range(1, 24)) line.insert(line.size(), random_non_lf());
         end
         6: begin   // wrong start character
            do line[0] = random_non_lf(); while (line[0] == mbar_pkg::CH_COLON);
         end
         7: begin   // one data digit that is not hex
            line[7 + $urandom_range(0, 7)] = random_non_hex();
         end
         8: begin   // short line, possibly empty
            keep = $urandom_range(0, 14);
            while (line.size() > keep) void'(line.pop_back());
         end
         9: begin   // noise, LF included
            line.delete();
            repeat ($urandom_range(1, 20)) begin
               c = $urandom;
               line.insert(line.size(), c);
            end
         end
         default: begin
         end
      endcase
      if (shape != 9 && $urandom_range(0, 3) != 0) line.insert(line.size(), mbar_pkg::CH_CR);
      foreach (line[i]) send_rx_char(line[i]);
      send_rx_char(mbar_pkg::CH_LF);
   endtask

   // stimulus
   initial begin
      logic [7:0] node_values [5];
      int phase_items;
      int phase_lfs;
      sb = new();
      node_values = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
      node_values[2] = $urandom;
      node_values[3] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: address extremes and wrap, then the parser's special cases
      send_item(mbar_pkg::OP_QUERY, 16'h0000, 8'h00, 8'h00);
      send_item(mbar_pkg::OP_QUERY, 16'hFFFF, 8'hFF, 8'hFF);
      send_item(mbar_pkg::OP_QUERY, 16'hFF80, 8'h80, 8'h5A);
      send_rx_char(mbar_pkg::CH_LF);
      send_text(":0");
      send_rx_char(mbar_pkg::CH_LF);
      send_text("Z");
      send_rx_char(mbar_pkg::CH_LF);
      send_text(":010404Fa09bC3d");
      send_rx_char(mbar_pkg::CH_CR);
      send_rx_char(mbar_pkg::CH_LF);
      wait_idle();

      // random phases, each under its own node address
      foreach (node_values[p]) begin
         write_node(node_values[p]);
         phase_items = items_sent;
         phase_lfs = lf_sent;
         while (items_sent - phase_items < 32 || lf_sent - phase_lfs < 2) begin
            if ($urandom_range(0, 3) == 0) send_random_query();
            else send_random_frame();
         end
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/mbar_pkg.sv
design/modbus_ascii_read_link.sv
tb/modbus_ascii_read_link_test.sv
